### hw/rtl/cvf_pkg.sv
// shared types and constants for the 2-d convolution filter
// no dependencies; imported by cvf_div and convolution_filter_2d_core
package cvf_pkg;

    // default geometry limits
    localparam int MAX_KERNEL_DEF   = 5;
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int MAX_CHANNELS_DEF = 4;

    // accumulator and divider operand width
    localparam int ACC_W = 42;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WEIGHTING = 3'd6;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_COEF  = 1'b1;

    // filter modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_NEG    = 2'd2;

    typedef struct packed {
        logic              command;
        logic [4:0]        coef_index;
        logic signed [15:0] coef_value;
        logic [7:0]        chan_0;
        logic [7:0]        chan_1;
        logic [7:0]        chan_2;
        logic [7:0]        chan_3;
    } item_t;

    typedef struct packed {
        logic [7:0]  res_0;
        logic [7:0]  res_1;
        logic [7:0]  res_2;
        logic [7:0]  res_3;
        logic [10:0] out_col;
        logic [15:0] out_row;
        logic        last_of_run;
    } result_t;

    // divider control and status
    typedef struct packed {
        logic start;
        logic off128;
        logic absval;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### hw/rtl/convolution_filter_2d_core.sv
// 2-d convolution filter with clamp-to-edge borders over a raster pixel stream
// depends on cvf_pkg and cvf_div
//
//  channel   handshake                 beat
//  item      item_valid / item_stall   pixel or kernel coefficient (item_t)
//  result    result_valid / result_stall  filtered pixel (result_t)
//  cfg       cfg_write                 register index and data, no wait
//
// a pixel beat writes the line memory in the cycle it is taken and gives 0 to
// 9 results; each result walks side*side taps through the line memory and
// then runs one divide per channel on the shared divider. a coefficient beat
// does not raise item_stall.
// item_stall is high while results of the last pixel are worked out; a
// finished result waits in the output register while the next is computed.
// reset clears control and kernel valid bits; the line memory is not cleared.
module convolution_filter_2d_core #(
    parameter int MAX_KERNEL   = cvf_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH    = cvf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = cvf_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cvf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cvf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  cvf_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output cvf_pkg::result_t                 result
);
    import cvf_pkg::*;

    localparam int TAPS = MAX_KERNEL * MAX_KERNEL;
    localparam int KAW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int XW   = CW + 2;
    localparam int AW   = $clog2(MAX_KERNEL * MAX_WIDTH);
    localparam int MMAX = (MAX_KERNEL - 1) / 2;
    localparam int PW   = 34;

    typedef enum logic [2:0] {S_IDLE, S_TAPS, S_DRAIN, S_DIV_START, S_DIV_WAIT, S_EMIT} state_t;

    // configuration registers
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  chans_reg;
    logic [2:0]  ksize_reg;
    logic [23:0] divisor_reg;
    logic [1:0]  mode_reg;
    logic        alpha_reg;

    // control state
    state_t          state_reg;
    logic [CW-1:0]   in_col_reg;
    logic [15:0]     in_row_reg;
    logic [SW-1:0]   in_slot_reg;
    logic [15:0]     item_r_reg;
    logic [SW-1:0]   item_slot_reg;
    logic [15:0]     ylo_reg, yhi_reg, y_reg;
    logic [CW-1:0]   xlo_reg, xhi_reg, x_reg;
    logic [2:0]      ty_reg, tx_reg;
    logic [KAW-1:0]  kt_reg;
    logic            v0_reg, v1_reg, v2_reg, v3_reg;
    logic [1:0]      ch_reg;
    logic            res_valid_reg;
    logic [TAPS-1:0] kval_reg;

    // memories
    logic [31:0] line_mem [MAX_KERNEL*MAX_WIDTH];
    logic [15:0] kern_mem [TAPS];

    // datapath registers
    logic [15:0]              s0_yy_reg;
    logic [CW-1:0]            s0_xx_reg;
    logic [KAW-1:0]           s0_kt_reg;
    logic [31:0]              px_reg;
    logic [15:0]              kq_reg;
    logic                     kv_reg;
    logic signed [24:0]       w_reg;
    logic [31:0]              bytes_reg;
    logic signed [PW-1:0]     prod_reg [4];
    logic signed [24:0]       w3_reg;
    logic signed [ACC_W-1:0]  tot_reg [4];
    logic signed [ACC_W-1:0]  wsum_reg;
    logic [7:0]               lane_reg [4];
    result_t                  out_reg;

    // effective geometry and mode
    logic [15:0]             w16;
    logic [WW-1:0]           w_eff;
    logic [CW-1:0]           wlast;
    logic [15:0]             h_eff;
    logic [15:0]             hlast;
    logic [2:0]              c_eff;
    logic [1:0]              a_idx;
    logic [2:0]              m_eff;
    logic [2:0]              side;
    logic signed [ACC_W-1:0] dv;
    logic                    off128;
    logic                    absval;

    always_comb
    begin
        w16 = 16'(width_reg);
        if (w16 == 16'd0)
            w_eff = WW'(1);
        else if (w16 > 16'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(w16);
        wlast = CW'(w_eff - WW'(1));
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        hlast = h_eff - 16'd1;
        if (chans_reg == 3'd0)
            c_eff = 3'd1;
        else if (32'(chans_reg) > MAX_CHANNELS)
            c_eff = 3'(MAX_CHANNELS);
        else
            c_eff = chans_reg;
        a_idx = 2'(c_eff - 3'd1);
        m_eff = (32'(ksize_reg >> 1) > MMAX) ? 3'(MMAX) : (ksize_reg >> 1);
        side  = 3'((m_eff << 1) + 3'd1);
        dv    = (divisor_reg == 24'd0) ? ACC_W'(256) : ACC_W'($signed(divisor_reg));
        off128 = (mode_reg == MODE_NEG);
        absval = (mode_reg != MODE_NORMAL) && (mode_reg != MODE_NEG);
    end

    // handshake
    logic item_acc, pix_acc, coef_acc;
    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign pix_acc    = item_acc && (item.command == CMD_PIXEL);
    assign coef_acc   = item_acc && (item.command == CMD_COEF);

    // position, window bounds and next position of an incoming pixel
    logic [15:0]   r_cur;
    logic [CW-1:0] c_cur;
    logic [SW-1:0] slot_cur;
    logic [AW-1:0] wr_addr;
    logic [15:0]   ylo_new, yhi_new;
    logic [CW-1:0] xlo_new, xhi_new;
    logic          y_empty, x_empty;
    logic [15:0]   row_next;
    logic [CW-1:0] col_next;
    logic [SW-1:0] slot_next;

    always_comb
    begin
        if (in_row_reg >= h_eff || WW'(in_col_reg) >= w_eff)
        begin
            r_cur    = '0;
            c_cur    = '0;
            slot_cur = '0;
        end
        else
        begin
            r_cur    = in_row_reg;
            c_cur    = in_col_reg;
            slot_cur = in_slot_reg;
        end
        wr_addr = AW'(32'(slot_cur) * MAX_WIDTH) + AW'(c_cur);

        // rows
        y_empty = 1'b0;
        if (r_cur != hlast)
        begin
            ylo_new = r_cur - 16'(m_eff);
            yhi_new = ylo_new;
            y_empty = (r_cur < 16'(m_eff));
        end
        else
        begin
            yhi_new = hlast;
            ylo_new = (hlast >= 16'(m_eff)) ? hlast - 16'(m_eff) : 16'd0;
        end

        // columns
        x_empty = 1'b0;
        if (c_cur != wlast)
        begin
            xlo_new = c_cur - CW'(m_eff);
            xhi_new = xlo_new;
            x_empty = (c_cur < CW'(m_eff));
        end
        else
        begin
            xhi_new = wlast;
            xlo_new = (wlast >= CW'(m_eff)) ? wlast - CW'(m_eff) : '0;
        end

        // raster advance
        if (c_cur == wlast)
        begin
            col_next = '0;
            if (r_cur == hlast)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = r_cur + 16'd1;
                slot_next = (32'(slot_cur) == MAX_KERNEL - 1) ? '0 : slot_cur + SW'(1);
            end
        end
        else
        begin
            col_next  = c_cur + CW'(1);
            row_next  = r_cur;
            slot_next = slot_cur;
        end
    end

    // tap address: clamp to edge
    logic signed [17:0]   yy_s;
    logic signed [XW-1:0] xx_s;
    logic [15:0]          yy;
    logic [CW-1:0]        xx;

    always_comb
    begin
        yy_s = $signed(18'(y_reg)) + $signed(18'(ty_reg)) - $signed(18'(m_eff));
        xx_s = $signed(XW'(x_reg)) + $signed(XW'(tx_reg)) - $signed(XW'(m_eff));
        if (yy_s < 0)
            yy = '0;
        else if (yy_s > $signed(18'(hlast)))
            yy = hlast;
        else
            yy = yy_s[15:0];
        if (xx_s < 0)
            xx = '0;
        else if (xx_s > $signed(XW'(wlast)))
            xx = wlast;
        else
            xx = xx_s[CW-1:0];
    end

    // line slot of a tap row, relative to the row of the current pixel
    logic [15:0]   diff16;
    logic [SW-1:0] diff_s;
    logic [SW-1:0] rd_slot;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        diff16 = item_r_reg - s0_yy_reg;
        diff_s = SW'(diff16);
        if (item_slot_reg >= diff_s)
            rd_slot = item_slot_reg - diff_s;
        else
            rd_slot = SW'((SW+1)'(item_slot_reg) + (SW+1)'(MAX_KERNEL) - (SW+1)'(diff_s));
        rd_addr = AW'(32'(rd_slot) * MAX_WIDTH) + AW'(s0_xx_reg);
    end

    // weight and products
    logic signed [15:0] k_s;
    logic [7:0]         abyte;
    logic signed [24:0] w_next;

    always_comb
    begin
        k_s = kv_reg ? $signed(kq_reg) : 16'sd0;
        case (a_idx)
            2'd0:    abyte = px_reg[7:0];
            2'd1:    abyte = px_reg[15:8];
            2'd2:    abyte = px_reg[23:16];
            default: abyte = px_reg[31:24];
        endcase
        w_next = alpha_reg ? (25'(k_s) * $signed({17'd0, abyte})) : 25'(k_s);
    end

    // divider operands
    div_ctl_t                div_ctl;
    div_sts_t                div_sts;
    logic [7:0]              div_q;
    logic signed [ACC_W-1:0] div_num;
    logic signed [ACC_W-1:0] div_den;

    always_comb
    begin
        div_ctl.start  = (state_reg == S_DIV_START);
        div_ctl.off128 = off128;
        div_ctl.absval = absval;
        if (alpha_reg && ch_reg == a_idx)
        begin
            div_num = wsum_reg;
            div_den = dv;
        end
        else
        begin
            div_num = tot_reg[ch_reg];
            div_den = (alpha_reg && wsum_reg != '0) ? wsum_reg : dv;
        end
    end

    cvf_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (div_ctl),
        .num  (div_num),
        .den  (div_den),
        .sts  (div_sts),
        .quo  (div_q)
    );

    // output load and loop control
    logic out_room, load, last_out, acc_clr, tap_last;
    assign out_room = !res_valid_reg || !result_stall;
    assign load     = (state_reg == S_EMIT) && out_room;
    assign last_out = (y_reg == yhi_reg) && (x_reg == xhi_reg);
    assign acc_clr  = (pix_acc && !y_empty && !x_empty) || (load && !last_out);
    assign tap_last = (ty_reg == side - 3'd1) && (tx_reg == side - 3'd1);

    // control state machine and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 12'd1;
            height_reg    <= 16'd1;
            chans_reg     <= 3'd4;
            ksize_reg     <= 3'd3;
            divisor_reg   <= 24'd256;
            mode_reg      <= MODE_NORMAL;
            alpha_reg     <= 1'b0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            item_r_reg    <= '0;
            item_slot_reg <= '0;
            ylo_reg       <= '0;
            yhi_reg       <= '0;
            y_reg         <= '0;
            xlo_reg       <= '0;
            xhi_reg       <= '0;
            x_reg         <= '0;
            ty_reg        <= '0;
            tx_reg        <= '0;
            kt_reg        <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            ch_reg        <= '0;
            res_valid_reg <= 1'b0;
            kval_reg      <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg   <= cfg_data[11:0];
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        in_slot_reg <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg  <= cfg_data[15:0];
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        in_slot_reg <= '0;
                    end
                    REG_CHANNEL_COUNT:   chans_reg   <= cfg_data[2:0];
                    REG_KERNEL_SIZE:     ksize_reg   <= cfg_data[2:0];
                    REG_DIVISOR:         divisor_reg <= cfg_data[23:0];
                    REG_FILTER_MODE:     mode_reg    <= cfg_data[1:0];
                    REG_ALPHA_WEIGHTING: alpha_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            // kernel valid bits
            if (coef_acc && 32'(item.coef_index) < TAPS)
                kval_reg[KAW'(item.coef_index)] <= 1'b1;

            // tap pipeline valids
            v0_reg <= (state_reg == S_TAPS);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            // output register
            if (load)
                res_valid_reg <= 1'b1;
            else if (result_valid && !result_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (pix_acc)
                    begin
                        in_col_reg    <= col_next;
                        in_row_reg    <= row_next;
                        in_slot_reg   <= slot_next;
                        item_r_reg    <= r_cur;
                        item_slot_reg <= slot_cur;
                        ylo_reg       <= ylo_new;
                        yhi_reg       <= yhi_new;
                        xlo_reg       <= xlo_new;
                        xhi_reg       <= xhi_new;
                        y_reg         <= ylo_new;
                        x_reg         <= xlo_new;
                        ty_reg        <= '0;
                        tx_reg        <= '0;
                        kt_reg        <= '0;
                        if (!y_empty && !x_empty)
                            state_reg <= S_TAPS;
                    end
                end
                S_TAPS:
                begin
                    kt_reg <= kt_reg + KAW'(1);
                    if (tx_reg == side - 3'd1)
                    begin
                        tx_reg <= '0;
                        ty_reg <= ty_reg + 3'd1;
                    end
                    else
                        tx_reg <= tx_reg + 3'd1;
                    if (tap_last)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!v0_reg && !v1_reg && !v2_reg && !v3_reg)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_DIV_START;
                    end
                end
                S_DIV_START:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (div_sts.done)
                    begin
                        if (3'(ch_reg) == c_eff - 3'd1)
                            state_reg <= S_EMIT;
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (load)
                    begin
                        ty_reg <= '0;
                        tx_reg <= '0;
                        kt_reg <= '0;
                        if (last_out)
                            state_reg <= S_IDLE;
                        else
                        begin
                            if (x_reg == xhi_reg)
                            begin
                                x_reg <= xlo_reg;
                                y_reg <= y_reg + 16'd1;
                            end
                            else
                                x_reg <= x_reg + CW'(1);
                            state_reg <= S_TAPS;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // line memory and kernel memory, registered read
    always_ff @(posedge clk)
    begin
        if (pix_acc)
            line_mem[wr_addr] <= {item.chan_3, item.chan_2, item.chan_1, item.chan_0};
        px_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_acc && 32'(item.coef_index) < TAPS)
            kern_mem[KAW'(item.coef_index)] <= item.coef_value;
        kq_reg <= kern_mem[s0_kt_reg];
        kv_reg <= kval_reg[s0_kt_reg];
    end

    // tap datapath and accumulators
    always_ff @(posedge clk)
    begin
        s0_yy_reg <= yy;
        s0_xx_reg <= xx;
        s0_kt_reg <= kt_reg;
        w_reg     <= w_next;
        bytes_reg <= px_reg;
        w3_reg    <= w_reg;
        for (int b = 0; b < 4; b++)
            prod_reg[b] <= PW'(w_reg) * $signed({26'd0, bytes_reg[8*b +: 8]});
        if (acc_clr)
        begin
            wsum_reg <= '0;
            for (int b = 0; b < 4; b++)
                tot_reg[b] <= '0;
        end
        else if (v3_reg)
        begin
            wsum_reg <= wsum_reg + ACC_W'(w3_reg);
            for (int b = 0; b < 4; b++)
                tot_reg[b] <= tot_reg[b] + ACC_W'(prod_reg[b]);
        end
    end

    // channel results and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV_WAIT && div_sts.done)
            lane_reg[ch_reg] <= div_q;
        if (load)
        begin
            out_reg.res_0       <= (c_eff > 3'd0) ? lane_reg[0] : 8'd0;
            out_reg.res_1       <= (c_eff > 3'd1) ? lane_reg[1] : 8'd0;
            out_reg.res_2       <= (c_eff > 3'd2) ? lane_reg[2] : 8'd0;
            out_reg.res_3       <= (c_eff > 3'd3) ? lane_reg[3] : 8'd0;
            out_reg.out_col     <= 11'(x_reg);
            out_reg.out_row     <= y_reg;
            out_reg.last_of_run <= last_out;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    // divider is only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider started while busy");

    // taps fully accumulated before any divide
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_START) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("divide started with taps in flight");

    // emitted position lies inside the window of the pixel
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (x_reg >= xlo_reg && x_reg <= xhi_reg &&
                  y_reg >= ylo_reg && y_reg <= yhi_reg))
        else $error("result outside output window");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("pending result lost");
`endif

endmodule

### hw/rtl/cvf_div.sv
// iterative divider: ceil(num/den + offset), optional absolute value, saturated to a byte
// depends on cvf_pkg
module cvf_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cvf_pkg::div_ctl_t                  ctl,
    input  logic signed [cvf_pkg::ACC_W-1:0]   num,
    input  logic signed [cvf_pkg::ACC_W-1:0]   den,
    output cvf_pkg::div_sts_t                  sts,
    output logic [7:0]                         quo
);
    import cvf_pkg::*;

    localparam int DW = ACC_W + 4;

    typedef enum logic [2:0] {D_IDLE, D_PREP, D_OFF, D_SAT, D_STEP} dstate_t;

    dstate_t               state_reg;
    logic signed [DW-1:0]  n_reg;
    logic signed [DW-1:0]  d_reg;
    logic [DW-1:0]         dsh_reg;
    logic [2:0]            bit_reg;
    logic [7:0]            q_reg;
    logic                  done_reg;
    logic                  off_reg;
    logic                  abs_reg;
    logic signed [DW-1:0]  p_off;
    logic signed [DW-1:0]  p_abs;

    // numerator after offset and absolute value
    always_comb
    begin
        p_off = n_reg + (off_reg ? (d_reg <<< 7) : '0);
        p_abs = (abs_reg && p_off < 0) ? -p_off : p_off;
    end

    // sequencer, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            n_reg     <= '0;
            d_reg     <= '0;
            dsh_reg   <= '0;
            bit_reg   <= '0;
            q_reg     <= '0;
            done_reg  <= 1'b0;
            off_reg   <= 1'b0;
            abs_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (ctl.start)
                    begin
                        n_reg     <= DW'(num);
                        d_reg     <= DW'(den);
                        off_reg   <= ctl.off128;
                        abs_reg   <= ctl.absval;
                        state_reg <= D_PREP;
                    end
                end
                D_PREP:
                begin
                    if (d_reg < 0)
                    begin
                        n_reg <= -n_reg;
                        d_reg <= -d_reg;
                    end
                    state_reg <= D_OFF;
                end
                D_OFF:
                begin
                    if (p_abs <= 0)
                    begin
                        q_reg     <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        n_reg     <= p_abs + d_reg - DW'(1);
                        state_reg <= D_SAT;
                    end
                end
                D_SAT:
                begin
                    if (n_reg >= (d_reg <<< 8))
                    begin
                        q_reg     <= 8'hFF;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        q_reg     <= '0;
                        dsh_reg   <= DW'(d_reg <<< 7);
                        bit_reg   <= 3'd7;
                        state_reg <= D_STEP;
                    end
                end
                D_STEP:
                begin
                    if ($unsigned(n_reg) >= dsh_reg)
                    begin
                        n_reg          <= n_reg - $signed(dsh_reg);
                        q_reg[bit_reg] <= 1'b1;
                    end
                    dsh_reg <= dsh_reg >> 1;
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign sts.busy = (state_reg != D_IDLE);
    assign sts.done = done_reg;
    assign quo      = q_reg;

endmodule
